>>> src/tnn2o_pkg.sv
// shared types and constants for the nearest-neighbour / 2-opt tour unit
// no dependencies
`timescale 1ns / 1ps
package tnn2o_pkg;
	localparam int MAX_CITIES_DEF = 32;
	localparam int DIST_BITS_DEF  = 25;
	localparam int CNT_BITS       = 6;
	localparam int CITY_BITS      = 5;
	localparam int TOTAL_BITS     = 30;
	localparam int PASS_LIMIT     = 1024;
	localparam int PASS_BITS      = 11;
	localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
	localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(4);

	// datapath commands
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_NN_INIT = 4'd1,  // mark only city 0, route[0]=0, cur=0
		OP_NN_RD   = 4'd2,  // issue read cur->j
		OP_NN_CMP  = 4'd3,  // compare read value
		OP_NN_TAKE = 4'd4,  // commit best to route[step]
		OP_TO_RD   = 4'd5,  // issue one of four 2-opt reads (sel)
		OP_TO_ACC  = 4'd6,  // accumulate read sum
		OP_TO_SWAP = 4'd7,  // swap route[lo], route[hi]
		OP_LEN_RD  = 4'd8,  // read edge for tour length
		OP_LEN_ACC = 4'd9   // add edge into total
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [1:0]           sel;
		logic [CITY_BITS:0]   i;
		logic [CITY_BITS:0]   j;
	} dp_cmd_t;

	typedef struct packed {
		logic visited;   // city j already on the route
		logic improve;   // alt < now
		logic same;      // a==c or b==d
	} dp_stat_t;
endpackage

>>> src/tour_nearest_neighbor_two_opt_unit.sv
// top level: closed-tour builder, nearest neighbour then 2-opt, over a loaded matrix
// depends on tnn2o_pkg, tnn2o_ctrl, tnn2o_datapath
//
// channel     | dir | content
// s_axis      | in  | one distance entry per request, row-major
// m_axis      | out | one tour city per request, tlast on final city
// cfg         | in  | city_count write
//
// loading accepts one entry per cycle; after the last entry the sequencer runs
// nearest neighbour over every (step, city) pair, then, for four or more cities,
// 2-opt over every (i,k) pair, reversing the segment on an improvement, bounded by
// 1024 passes; the length sum reads one edge per city; then n results go out,
// one per accepted request.
// no input is accepted from the last entry until the last result is taken.
// reset returns to loading with city_count 4; a cfg write during loading restarts the load.
`timescale 1ns / 1ps
module tour_nearest_neighbor_two_opt_unit #(
	parameter int MAX_CITIES = tnn2o_pkg::MAX_CITIES_DEF,
	parameter int DIST_BITS  = tnn2o_pkg::DIST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [24:0] distance_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // city_index, visit_position, total_distance
	output logic        m_axis_tlast,   // last_of_route
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata       // city_count
);
	import tnn2o_pkg::*;
	localparam int AW = $clog2(MAX_CITIES*MAX_CITIES);

	logic [CNT_BITS-1:0] cc_q, n;
	logic [AW-1:0]       ld_addr;
	dp_cmd_t             cmd;
	dp_stat_t            stat;
	logic [CITY_BITS:0]  out_pos;
	logic [CITY_BITS-1:0] out_city;
	logic [TOTAL_BITS-1:0] total;
	logic                in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cc_q <= COUNT_RESET;
		else if (cfg_we) cc_q <= cfg_wdata;
	end
	// zero acts as one, clamp to capacity
	assign n = (cc_q == '0) ? CNT_BITS'(1) :
		(32'(cc_q) > MAX_CITIES) ? CNT_BITS'(MAX_CITIES) : cc_q;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	tnn2o_ctrl #(.MAX_CITIES(MAX_CITIES)) u_ctrl (
		.clk, .arst_n, .n, .cfg_we, .in_fire, .in_rdy(s_axis_tready), .ld_addr,
		.cmd, .stat, .out_vld(m_axis_tvalid), .out_rdy(m_axis_tready), .out_pos,
		.out_last(m_axis_tlast)
	);

	tnn2o_datapath #(.MAX_CITIES(MAX_CITIES), .DIST_BITS(DIST_BITS)) u_dp (
		.clk, .arst_n, .ld_we(in_fire), .ld_addr, .ld_data(s_axis_tdata[DIST_BITS-1:0]),
		.n, .cmd, .stat, .out_pos, .out_city, .total
	);

	assign m_axis_tdata = {
		(m_axis_tlast ? total : {TOTAL_BITS{1'b0}}),
		CITY_BITS'(out_pos),
		out_city
	};

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("load and emit overlap");
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (32'(out_pos) + 1 == 32'(n)))
		else $error("tlast at wrong position");
	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("no return to load");
`endif
endmodule

>>> src/tnn2o_datapath.sv
// datapath: distance memory, route registers, nearest-neighbour and 2-opt arithmetic
// depends on tnn2o_pkg
`timescale 1ns / 1ps
module tnn2o_datapath #(
	parameter int MAX_CITIES = tnn2o_pkg::MAX_CITIES_DEF,
	parameter int DIST_BITS  = tnn2o_pkg::DIST_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                ld_we,
	input  logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0] ld_addr,
	input  logic [DIST_BITS-1:0]                ld_data,
	input  logic [tnn2o_pkg::CNT_BITS-1:0]      n,
	input  tnn2o_pkg::dp_cmd_t                  cmd,
	output tnn2o_pkg::dp_stat_t                 stat,
	input  logic [tnn2o_pkg::CITY_BITS:0]       out_pos,
	output logic [tnn2o_pkg::CITY_BITS-1:0]     out_city,
	output logic [tnn2o_pkg::TOTAL_BITS-1:0]    total
);
	import tnn2o_pkg::*;
	localparam int AW = $clog2(MAX_CITIES*MAX_CITIES);
	localparam int IW = $clog2(MAX_CITIES);
	localparam int SW = DIST_BITS + 1;

	logic [DIST_BITS-1:0] mem [MAX_CITIES*MAX_CITIES];
	logic [DIST_BITS-1:0] rd_q;
	logic [AW-1:0]        rd_addr;
	logic [IW-1:0]        route_q [MAX_CITIES];
	logic [MAX_CITIES-1:0] vis_q;
	logic [IW-1:0]        cur_q, best_q;
	logic                 found_q;
	logic [DIST_BITS-1:0] best_d_q;
	logic [SW-1:0]        now_q, alt_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [IW-1:0]        ra, rb, rc, rd, fr, to;
	logic [IW-1:0]        ii, jj, jn;
	logic [TOTAL_BITS:0]  tsum;

	assign ii = cmd.i[IW-1:0];
	assign jj = cmd.j[IW-1:0];
	assign jn = (cmd.j + 1'b1 >= {1'b0, n}) ? '0 : IW'(cmd.j + 1'b1);
	// 2-opt corners: a=r[i-1] b=r[i] c=r[k] d=r[k+1 mod n]
	assign ra = route_q[IW'(cmd.i - 1'b1)];
	assign rb = route_q[ii];
	assign rc = route_q[jj];
	assign rd = route_q[jn];

	always_comb begin
		fr = cur_q;
		to = jj;
		case (cmd.op)
			OP_TO_RD: begin
				case (cmd.sel)
					2'd0: begin fr = ra; to = rb; end
					2'd1: begin fr = rc; to = rd; end
					2'd2: begin fr = ra; to = rc; end
					default: begin fr = rb; to = rd; end
				endcase
			end
			OP_LEN_RD: begin fr = rc; to = rd; end
			default: begin fr = cur_q; to = jj; end
		endcase
	end
	// from*n+to, narrow multiply
	assign rd_addr = AW'(fr * n + to);

	always_ff @(posedge clk) begin
		if (ld_we) mem[ld_addr] <= ld_data;
		rd_q <= mem[rd_addr];
	end

	assign tsum = {1'b0, total_q} + (TOTAL_BITS+1)'(rd_q);
	assign stat.visited = vis_q[jj];
	// the b->d edge joins alt as it arrives on the last accumulate
	assign stat.improve = (alt_q + SW'(rd_q)) < now_q;
	assign stat.same    = (ra == rc) || (rb == rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q   <= '0;
			found_q <= 1'b0;
			total_q <= '0;
		end else begin
			case (cmd.op)
				OP_NN_INIT: begin
					vis_q   <= MAX_CITIES'(1);
					found_q <= 1'b0;
					total_q <= '0;
				end
				OP_NN_CMP: begin
					if (!found_q || rd_q < best_d_q) found_q <= 1'b1;
				end
				OP_NN_TAKE: begin
					vis_q[best_q] <= 1'b1;
					found_q       <= 1'b0;
				end
				OP_LEN_ACC: total_q <= tsum[TOTAL_BITS] ? TOTAL_MAX : tsum[TOTAL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_NN_INIT: begin
				route_q[0] <= '0;
				cur_q      <= '0;
			end
			OP_NN_CMP: begin
				if (!found_q || rd_q < best_d_q) begin
					best_q   <= jj;
					best_d_q <= rd_q;
				end
			end
			OP_NN_TAKE: begin
				route_q[ii] <= best_q;
				cur_q       <= best_q;
			end
			OP_TO_ACC: begin
				case (cmd.sel)
					2'd0: now_q <= SW'(rd_q);
					2'd1: now_q <= now_q + SW'(rd_q);
					2'd2: alt_q <= SW'(rd_q);
					default: alt_q <= alt_q + SW'(rd_q);
				endcase
			end
			OP_TO_SWAP: begin
				if (ii != jj) begin
					route_q[ii] <= route_q[jj];
					route_q[jj] <= route_q[ii];
				end
			end
			default: ;
		endcase
	end

	assign out_city = CITY_BITS'(route_q[out_pos[IW-1:0]]);
	assign total    = total_q;
endmodule

>>> src/tnn2o_ctrl.sv
// controller: load counting, build/optimize/length sequencing and result emission
// depends on tnn2o_pkg
`timescale 1ns / 1ps
module tnn2o_ctrl #(
	parameter int MAX_CITIES = tnn2o_pkg::MAX_CITIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [tnn2o_pkg::CNT_BITS-1:0]    n,
	input  logic                              cfg_we,
	input  logic                              in_fire,
	output logic                              in_rdy,
	output logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0] ld_addr,
	output tnn2o_pkg::dp_cmd_t                cmd,
	input  tnn2o_pkg::dp_stat_t               stat,
	output logic                              out_vld,
	input  logic                              out_rdy,
	output logic [tnn2o_pkg::CITY_BITS:0]     out_pos,
	output logic                              out_last
);
	import tnn2o_pkg::*;
	localparam int AW = $clog2(MAX_CITIES*MAX_CITIES);

	typedef enum logic [10:0] {
		S_LOAD  = 11'b00000000001,
		S_INIT  = 11'b00000000010,
		S_NRD   = 11'b00000000100,
		S_NCMP  = 11'b00000001000,
		S_NTAKE = 11'b00000010000,
		S_TRD   = 11'b00000100000,
		S_TACC  = 11'b00001000000,
		S_TSWP  = 11'b00010000000,
		S_LRD   = 11'b00100000000,
		S_LACC  = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} st_t;

	st_t st_q;
	logic [AW:0]          cnt_q;
	logic [CITY_BITS:0]   i_q, j_q, lo_q, hi_q, ki_q;
	logic [1:0]           sel_q;
	logic                 imp_q;
	logic [PASS_BITS-1:0] pass_q;
	logic [AW:0]          total_e;
	logic [CITY_BITS:0]   nn;

	assign nn      = (CITY_BITS+1)'(n);
	assign total_e = (AW+1)'(n * n);
	assign in_rdy  = st_q == S_LOAD;
	assign ld_addr = cnt_q[AW-1:0];
	assign out_vld = st_q == S_OUT;
	assign out_pos = i_q;
	assign out_last = i_q + 1'b1 == nn;

	always_comb begin
		cmd = '{op: OP_NONE, sel: sel_q, i: i_q, j: j_q};
		case (st_q)
			S_INIT:  cmd.op = OP_NN_INIT;
			S_NRD:   cmd.op = OP_NN_RD;
			S_NCMP:  cmd.op = stat.visited ? OP_NONE : OP_NN_CMP;
			S_NTAKE: cmd.op = OP_NN_TAKE;
			S_TRD:   cmd.op = OP_TO_RD;
			S_TACC:  cmd.op = OP_TO_ACC;
			S_TSWP:  begin cmd.op = OP_TO_SWAP; cmd.i = lo_q; cmd.j = hi_q; end
			S_LRD:   cmd.op = OP_LEN_RD;
			S_LACC:  cmd.op = OP_LEN_ACC;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD; cnt_q <= '0; i_q <= '0; j_q <= '0; sel_q <= '0;
			imp_q <= 1'b0; pass_q <= '0; lo_q <= '0; hi_q <= '0; ki_q <= '0;
		end else begin
			case (st_q)
				S_LOAD: begin
					if (cfg_we) cnt_q <= '0;
					else if (in_fire) begin
						if (cnt_q + 1'b1 >= total_e) begin
							cnt_q <= '0;
							st_q  <= S_INIT;
						end else cnt_q <= cnt_q + 1'b1;
					end
				end
				S_INIT: begin
					i_q <= (CITY_BITS+1)'(1); j_q <= '0;
					st_q <= (nn == 1) ? S_OUT : S_NRD;
					if (nn == 1) i_q <= '0;
				end
				S_NRD: st_q <= S_NCMP;
				S_NCMP: begin
					if (j_q + 1'b1 == nn) st_q <= S_NTAKE;
					else begin j_q <= j_q + 1'b1; st_q <= S_NRD; end
				end
				S_NTAKE: begin
					j_q <= '0;
					if (i_q + 1'b1 == nn) begin
						if (nn >= 4) begin
							i_q <= (CITY_BITS+1)'(1); j_q <= (CITY_BITS+1)'(2);
							sel_q <= '0; imp_q <= 1'b0; pass_q <= PASS_BITS'(1);
							st_q <= S_TRD;
						end else begin
							j_q <= '0; st_q <= S_LRD;
						end
					end else begin
						i_q <= i_q + 1'b1; st_q <= S_NRD;
					end
				end
				S_TRD: st_q <= S_TACC;
				S_TACC: begin
					if (sel_q != 2'd3) begin sel_q <= sel_q + 1'b1; st_q <= S_TRD; end
					else begin
						sel_q <= '0;
						if (!stat.same && stat.improve) begin
							imp_q <= 1'b1; lo_q <= i_q; hi_q <= j_q; ki_q <= j_q;
							st_q <= S_TSWP;
						end else if (stat.same) begin
							// skipped pair, fall through to advance
							st_q <= S_TSWP; lo_q <= j_q; hi_q <= j_q; ki_q <= j_q;
						end else begin
							st_q <= S_TSWP; lo_q <= j_q; hi_q <= j_q; ki_q <= j_q;
						end
					end
				end
				S_TSWP: begin
					if (lo_q + 1'b1 < hi_q) begin
						lo_q <= lo_q + 1'b1; hi_q <= hi_q - 1'b1;
					end else begin
						// advance (i,k)
						st_q <= S_TRD;
						if (ki_q + 1'b1 < nn) j_q <= ki_q + 1'b1;
						else if (i_q + 2'd2 < nn) begin
							i_q <= i_q + 1'b1; j_q <= i_q + 2'd2;
						end else if (imp_q && pass_q != PASS_BITS'(PASS_LIMIT)) begin
							i_q <= (CITY_BITS+1)'(1); j_q <= (CITY_BITS+1)'(2);
							imp_q <= 1'b0; pass_q <= pass_q + 1'b1;
						end else begin
							j_q <= '0; st_q <= S_LRD;
						end
					end
				end
				S_LRD: st_q <= S_LACC;
				S_LACC: begin
					if (j_q + 1'b1 == nn) begin i_q <= '0; st_q <= S_OUT; end
					else begin j_q <= j_q + 1'b1; st_q <= S_LRD; end
				end
				S_OUT: begin
					if (out_rdy) begin
						if (out_last) st_q <= S_LOAD;
						else i_q <= i_q + 1'b1;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end
endmodule

>>> dv/tb_top.sv
// testbench for tour_nearest_neighbor_two_opt_unit: loads distance matrices,
// predicts each tour (nearest neighbour then 2-opt) and checks every emitted city
// depends on tnn2o_pkg and the rtl under src
`timescale 1ns / 1ps
module tb_top;
	import tnn2o_pkg::*;

	typedef struct packed {
		logic [CITY_BITS-1:0]  city;
		logic [CITY_BITS-1:0]  pos;
		logic [TOTAL_BITS-1:0] total;
		logic                  last;
	} tour_stop_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [5:0]  cfg_wdata;

	tour_nearest_neighbor_two_opt_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [DIST_BITS_DEF-1:0] dist_mem [MAX_CITIES_DEF*MAX_CITIES_DEF];
	logic [CNT_BITS-1:0]      count_reg;
	int                       load_idx;
	int                       route [MAX_CITIES_DEF];
	tour_stop_t               expected_stops [$];
	int                       err_count;
	bit                       idle_en;
	int                       matrix [MAX_CITIES_DEF][MAX_CITIES_DEF];

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic int active_cities();
		if (count_reg == 0) return 1;
		if (count_reg > MAX_CITIES_DEF) return MAX_CITIES_DEF;
		return int'(count_reg);
	endfunction

	function automatic longint edge_len(int n, int from, int to);
		return longint'(dist_mem[from*n + to]);
	endfunction

	// nearest neighbour from city 0, then 2-opt, then closed length; queue the stops
	function automatic void predict_tour(int n);
		bit     seen [MAX_CITIES_DEF];
		int     cur, best, lo, hi, tmp, a, b, c, d, passes;
		longint best_d, dj, now_len, alt_len, sum;
		bit     found, improved;
		tour_stop_t s;
		foreach (seen[x]) seen[x] = 0;
		seen[0] = 1;
		route[0] = 0;
		cur = 0;
		for (int step = 1; step < n; step++) begin
			found = 0;
			best = 0;
			best_d = 0;
			for (int j = 0; j < n; j++) begin
				if (seen[j]) continue;
				dj = edge_len(n, cur, j);
				// strict compare keeps the lowest index on ties
				if (!found || dj < best_d) begin
					found = 1;
					best = j;
					best_d = dj;
				end
			end
			seen[best] = 1;
			route[step] = best;
			cur = best;
		end
		if (n >= 4) begin
			improved = 1;
			passes = 0;
			while (improved && passes < PASS_LIMIT) begin
				improved = 0;
				passes++;
				for (int i = 1; i + 1 < n; i++) begin
					for (int k = i + 1; k < n; k++) begin
						a = route[i-1];
						b = route[i];
						c = route[k];
						d = route[(k+1) % n];
						if (a == c || b == d) continue;
						now_len = edge_len(n, a, b) + edge_len(n, c, d);
						alt_len = edge_len(n, a, c) + edge_len(n, b, d);
						if (alt_len < now_len) begin
							lo = i;
							hi = k;
							while (lo < hi) begin
								tmp = route[lo];
								route[lo] = route[hi];
								route[hi] = tmp;
								lo++;
								hi--;
							end
							improved = 1;
						end
					end
				end
			end
		end
		sum = 0;
		if (n >= 2) begin
			for (int i = 0; i < n; i++) begin
				sum += edge_len(n, route[i], route[(i+1) % n]);
				if (sum > longint'(TOTAL_MAX)) sum = longint'(TOTAL_MAX);
			end
		end
		for (int p = 0; p < n; p++) begin
			s.city  = route[p][CITY_BITS-1:0];
			s.pos   = p[CITY_BITS-1:0];
			s.last  = (p + 1 == n);
			s.total = s.last ? sum[TOTAL_BITS-1:0] : '0;
			expected_stops.insert(expected_stops.size(), s);
		end
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// source side: random idle bursts, valid held across back-to-back requests
	task automatic send_distance(logic [DIST_BITS_DEF-1:0] value);
		int n;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, value};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n = active_cities();
		if (load_idx >= n*n) load_idx = 0;
		dist_mem[load_idx] = value;
		load_idx++;
		if (load_idx >= n*n) begin
			load_idx = 0;
			predict_tour(n);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_stops.size() != 0) @(posedge clk);
		// a partial load can still be in flight, give the loader time
		repeat (10) @(posedge clk);
	endtask

	task automatic write_city_count(logic [5:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		count_reg = v;
		load_idx  = 0;
	endtask

	// fill matrix: 0 random full, 1 symmetric full, 2 symmetric tiny (ties), 3 constant
	task automatic fill_matrix(int n, int mode, logic [DIST_BITS_DEF-1:0] fixed_val);
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				case (mode)
					0: begin
						matrix[i][j] = $urandom() & 32'h1FF_FFFF;
					end
					1: begin
						if (j >= i) matrix[i][j] = $urandom() & 32'h1FF_FFFF;
						else matrix[i][j] = matrix[j][i];
					end
					2: begin
						if (j >= i) matrix[i][j] = $urandom_range(0, 3);
						else matrix[i][j] = matrix[j][i];
					end
					default: begin
						matrix[i][j] = int'(fixed_val);
					end
				endcase
			end
		end
	endtask

	task automatic send_matrix(int n);
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				send_distance(matrix[i][j][DIST_BITS_DEF-1:0]);
	endtask

	// reset value of city_count is 4, no write before the first matrix
	task automatic test_reset_count();
		fill_matrix(4, 3, 25'h1FF_FFFF);
		send_matrix(4);
		fill_matrix(4, 1, 0);
		send_matrix(4);
	endtask

	// one city (also count 0), then two and three cities where 2-opt is skipped
	task automatic test_small_tours();
		write_city_count(6'd1);
		send_distance(25'h1FF_FFFF);
		write_city_count(6'd0);
		send_distance(25'd0);
		write_city_count(6'd2);
		fill_matrix(2, 0, 0);
		send_matrix(2);
		write_city_count(6'd3);
		fill_matrix(3, 2, 0);
		send_matrix(3);
	endtask

	// tied distances push nearest neighbour to the lowest index
	task automatic test_ties();
		write_city_count(6'd5);
		fill_matrix(5, 3, 25'd7);
		send_matrix(5);
		fill_matrix(5, 2, 0);
		send_matrix(5);
	endtask

	// asymmetric matrix, passes may hit the limit
	task automatic test_asymmetric();
		write_city_count(6'd4);
		fill_matrix(4, 0, 0);
		send_matrix(4);
	endtask

	// a count write mid-load throws away the partial matrix
	task automatic test_load_restart();
		write_city_count(6'd4);
		repeat (7) send_distance(DIST_BITS_DEF'($urandom()));
		write_city_count(6'd4);
		fill_matrix(4, 1, 0);
		send_matrix(4);
	endtask

	task automatic test_random_tours();
		int sent, n, mode;
		sent = 0;
		while (sent < 85) begin
			if (sent > 60) idle_en = 0;
			n = $urandom_range(0, 8);
			write_city_count(n[5:0]);
			n = (n == 0) ? 1 : n;
			if ($urandom_range(0, 9) == 0) begin
				// broken load abandoned by a count write
				repeat ($urandom_range(1, n*n)) send_distance(DIST_BITS_DEF'($urandom()));
				write_city_count(n[5:0]);
			end
			mode = $urandom_range(0, 9);
			mode = (mode < 5) ? 1 : (mode < 7) ? 2 : (mode < 9) ? 0 : 3;
			fill_matrix(n, mode, DIST_BITS_DEF'($urandom()));
			send_matrix(n);
			sent += n*n;
		end
	endtask

	// sink side: checks every accepted result and stalls in random bursts
	initial begin
		int stall;
		tour_stop_t want;
		stall = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_stops.size() == 0) begin
					report_mismatch("unexpected result", longint'(m_axis_tdata[4:0]),
						longint'(-1));
				end else begin
					want = expected_stops.pop_front();
					if (m_axis_tdata[4:0] !== want.city)
						report_mismatch("city_index", longint'(m_axis_tdata[4:0]),
							longint'(want.city));
					if (m_axis_tdata[9:5] !== want.pos)
						report_mismatch("visit_position", longint'(m_axis_tdata[9:5]),
							longint'(want.pos));
					if (m_axis_tdata[39:10] !== want.total)
						report_mismatch("total_distance", longint'(m_axis_tdata[39:10]),
							longint'(want.total));
					if (m_axis_tlast !== want.last)
						report_mismatch("last_of_route", longint'(m_axis_tlast),
							longint'(want.last));
				end
			end
			if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(0, 10);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#100ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		count_reg     = COUNT_RESET;
		load_idx      = 0;
		err_count     = 0;
		idle_en       = 1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_count();
		test_small_tours();
		test_ties();
		test_asymmetric();
		test_load_restart();
		test_random_tours();
		drain_results();
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
